[design/biou_pkg.sv]
package biou_pkg;

    // Depth of the job queue between the geometry front end and the divider.
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Fill status that the job queue reports to its producer.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[design/biou_front.sv]
module biou_front
    import biou_pkg::*;
#(
    parameter int COORD_BITS = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  first_left,
    input  logic signed [COORD_BITS-1:0]  first_top,
    input  logic        [COORD_BITS-2:0]  first_width,
    input  logic        [COORD_BITS-2:0]  first_height,
    input  logic signed [COORD_BITS-1:0]  second_left,
    input  logic signed [COORD_BITS-1:0]  second_top,
    input  logic        [COORD_BITS-2:0]  second_width,
    input  logic        [COORD_BITS-2:0]  second_height,
    input  queue_status_t                 queue_status,
    output logic                          push_valid,
    output logic [2*(COORD_BITS-1)-1:0]   push_num,
    output logic [2*(COORD_BITS-1):0]     push_den,
    output logic                          push_flag
);

    localparam int SIZE_BITS = COORD_BITS - 1;
    localparam int AREA_BITS = 2 * SIZE_BITS;
    localparam int DEN_BITS  = AREA_BITS + 1;
    localparam int EDGE_BITS = COORD_BITS + 1;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    logic signed [EDGE_BITS-1:0] left_a;
    logic signed [EDGE_BITS-1:0] left_b;
    logic signed [EDGE_BITS-1:0] top_a;
    logic signed [EDGE_BITS-1:0] top_b;
    logic signed [EDGE_BITS-1:0] right_a;
    logic signed [EDGE_BITS-1:0] right_b;
    logic signed [EDGE_BITS-1:0] bottom_a;
    logic signed [EDGE_BITS-1:0] bottom_b;
    logic signed [EDGE_BITS-1:0] ovl_left;
    logic signed [EDGE_BITS-1:0] ovl_top;
    logic signed [EDGE_BITS-1:0] ovl_right;
    logic signed [EDGE_BITS-1:0] ovl_bottom;
    logic        [EDGE_BITS-1:0] span_x;
    logic        [EDGE_BITS-1:0] span_y;

    logic [SIZE_BITS-1:0] dx_next;
    logic [SIZE_BITS-1:0] dy_next;
    logic                 hit_next;
    logic [AREA_BITS-1:0] area_a_next;
    logic [AREA_BITS-1:0] area_b_next;

    logic [SIZE_BITS-1:0] dx_reg;
    logic [SIZE_BITS-1:0] dy_reg;
    logic                 s1_hit_reg;
    logic [AREA_BITS-1:0] area_a_reg;
    logic [AREA_BITS-1:0] area_b_reg;

    logic [AREA_BITS-1:0] inter_next;
    logic [DEN_BITS-1:0]  sum_next;
    logic [AREA_BITS-1:0] inter_reg;
    logic [DEN_BITS-1:0]  sum_reg;
    logic                 s2_hit_reg;

    logic [AREA_BITS-1:0] num_next;
    logic [DEN_BITS-1:0]  den_next;
    logic [AREA_BITS-1:0] num_reg;
    logic [DEN_BITS-1:0]  den_reg;
    logic                 s3_hit_reg;

    // Each stage loads when it is empty or the stage after it moves on.
    assign s3_ready = !s3_valid_reg || !queue_status.full;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Box edges, one bit wider than a coordinate so that right and bottom cannot wrap.
    always_comb
    begin
        left_a   = {first_left[COORD_BITS-1], first_left};
        left_b   = {second_left[COORD_BITS-1], second_left};
        top_a    = {first_top[COORD_BITS-1], first_top};
        top_b    = {second_top[COORD_BITS-1], second_top};
        right_a  = left_a + {2'b00, first_width};
        right_b  = left_b + {2'b00, second_width};
        bottom_a = top_a + {2'b00, first_height};
        bottom_b = top_b + {2'b00, second_height};
    end

    // Overlap rectangle and its extents; an extent never exceeds either box size when the boxes overlap.
    always_comb
    begin
        ovl_left    = (left_a > left_b) ? left_a : left_b;
        ovl_top     = (top_a > top_b) ? top_a : top_b;
        ovl_right   = (right_a < right_b) ? right_a : right_b;
        ovl_bottom  = (bottom_a < bottom_b) ? bottom_a : bottom_b;
        span_x      = ovl_right - ovl_left;
        span_y      = ovl_bottom - ovl_top;
        hit_next    = (ovl_left < ovl_right) && (ovl_top < ovl_bottom);
        dx_next     = span_x[SIZE_BITS-1:0];
        dy_next     = span_y[SIZE_BITS-1:0];
        area_a_next = AREA_BITS'(first_width) * AREA_BITS'(first_height);
        area_b_next = AREA_BITS'(second_width) * AREA_BITS'(second_height);
    end

    // Intersection area and the sum of both box areas.
    always_comb
    begin
        inter_next = AREA_BITS'(dx_reg) * AREA_BITS'(dy_reg);
        sum_next   = {1'b0, area_a_reg} + {1'b0, area_b_reg};
    end

    // Union area; an empty overlap becomes the trivial job zero over one.
    always_comb
    begin
        if (s2_hit_reg)
        begin
            num_next = inter_reg;
            den_next = sum_reg - {1'b0, inter_reg};
        end
        else
        begin
            num_next = '0;
            den_next = DEN_BITS'(1);
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            s1_hit_reg <= hit_next;
            area_a_reg <= area_a_next;
            area_b_reg <= area_b_next;
        end
        if (s2_ready)
        begin
            inter_reg  <= inter_next;
            sum_reg    <= sum_next;
            s2_hit_reg <= s1_hit_reg;
        end
        if (s3_ready)
        begin
            num_reg    <= num_next;
            den_reg    <= den_next;
            s3_hit_reg <= s2_hit_reg;
        end
    end

    assign push_valid = s3_valid_reg;
    assign push_num   = num_reg;
    assign push_den   = den_reg;
    assign push_flag  = s3_hit_reg;

    // The divider expects a ratio no larger than one over a non-zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> ({1'b0, num_reg} <= den_reg) && (den_reg != '0))
        else $error("front end produced a job with numerator above divisor");

    // An empty overlap must leave a zero numerator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_hit_reg) |-> (num_reg == '0))
        else $error("empty overlap carried a non-zero intersection");

endmodule

[design/biou_queue.sv]
module biou_queue
    import biou_pkg::*;
#(
    parameter int WIDTH = 50
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop_ready,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data,
    output queue_status_t    status
);

    logic [WIDTH-1:0]            entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0]   rd_ptr_reg;
    logic [QUEUE_COUNT_BITS-1:0] count_reg;
    logic [QUEUE_PTR_BITS-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0]   rd_ptr_next;
    logic [QUEUE_COUNT_BITS-1:0] count_next;
    logic                        push;
    logic                        pop;

    assign status.full  = (count_reg == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign push         = push_valid && !status.full;
    assign pop          = pop_ready && !status.empty;
    assign pop_valid    = !status.empty;
    assign pop_data     = entries_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? QUEUE_PTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QUEUE_PTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QUEUE_COUNT_BITS'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QUEUE_COUNT_BITS'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Occupancy never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_COUNT_BITS'(QUEUE_DEPTH))
        else $error("job queue occupancy above depth");

    // A lone push grows the occupancy by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == QUEUE_COUNT_BITS'($past(count_reg) + 1'b1)))
        else $error("job queue lost a pushed entry");

endmodule

[design/biou_divider.sv]
module biou_divider
    import biou_pkg::*;
#(
    parameter int AREA_BITS     = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  logic [AREA_BITS-1:0]   job_num,
    input  logic [AREA_BITS:0]     job_den,
    input  logic                   job_flag,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [FRACTION_BITS:0] overlap_ratio,
    output logic                   boxes_overlap
);

    localparam int DEN_BITS = AREA_BITS + 1;
    localparam int QUO_BITS = FRACTION_BITS + 1;
    localparam int STAGES   = FRACTION_BITS + 1;

    logic                valid_reg [STAGES];
    logic                flag_reg  [STAGES];
    logic [DEN_BITS-1:0] den_reg   [STAGES];
    logic [DEN_BITS-1:0] rem_reg   [STAGES];
    logic [QUO_BITS-1:0] quo_reg   [STAGES];
    logic [DEN_BITS-1:0] rem_next  [STAGES];
    logic [QUO_BITS-1:0] quo_next  [STAGES];

    logic                advance;
    logic [DEN_BITS-1:0] num_ext;
    logic                int_bit;

    // The whole pipe moves whenever the output slot is free or being taken.
    assign advance   = !valid_reg[STAGES-1] || out_ready;
    assign job_ready = advance;

    // First stage: the integer bit, which is one only for a full match.
    always_comb
    begin
        num_ext     = {1'b0, job_num};
        int_bit     = (num_ext >= job_den);
        rem_next[0] = int_bit ? (num_ext - job_den) : num_ext;
        quo_next[0] = QUO_BITS'(int_bit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flag_reg[0] <= job_flag;
            den_reg[0]  <= job_den;
            rem_reg[0]  <= rem_next[0];
            quo_reg[0]  <= quo_next[0];
        end
    end

    // Fraction stages: one restoring step, one quotient bit each.
    for (genvar i = 1; i < STAGES; i++)
    begin : g_step
        logic [DEN_BITS:0] trial;
        logic [DEN_BITS:0] diff;
        logic              take;

        always_comb
        begin
            trial       = {rem_reg[i-1], 1'b0};
            diff        = trial - {1'b0, den_reg[i-1]};
            take        = (trial >= {1'b0, den_reg[i-1]});
            rem_next[i] = take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            quo_next[i] = {quo_reg[i-1][QUO_BITS-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                flag_reg[i] <= flag_reg[i-1];
                den_reg[i]  <= den_reg[i-1];
                rem_reg[i]  <= rem_next[i];
                quo_reg[i]  <= quo_next[i];
            end
        end
    end

    assign out_valid     = valid_reg[STAGES-1];
    assign overlap_ratio = quo_reg[STAGES-1];
    assign boxes_overlap = flag_reg[STAGES-1];

    // The ratio never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (overlap_ratio <= (QUO_BITS'(1) << FRACTION_BITS)))
        else $error("overlap ratio above one");

    // Disjoint boxes give a zero ratio.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !boxes_overlap) |-> (overlap_ratio == '0))
        else $error("non-zero ratio without overlap");

endmodule

[design/box_intersection_over_union_core.sv]
// Intersection over union of two axis-aligned boxes, each given as a signed
// corner and an unsigned width and height. The result is the overlap area over
// the union area as unsigned fixed point with FRACTION_BITS fraction bits,
// truncated, plus a flag that is set when the boxes overlap; boxes that only
// touch, or have zero size, give zero with the flag clear. One box pair is
// accepted every clock cycle while in_ready is high. From input to output a
// pair passes the registered edge, area and union stages of the front end, a
// four-entry job queue, and a pipelined restoring divider that forms one
// quotient bit per stage. The queue lets the arithmetic front keep accepting
// pairs while the output side is stalled, until the queue is full.
module box_intersection_over_union_core
    import biou_pkg::*;
#(
    parameter int COORD_BITS    = 13,
    parameter int FRACTION_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] first_left,
    input  logic signed [COORD_BITS-1:0] first_top,
    input  logic        [COORD_BITS-2:0] first_width,
    input  logic        [COORD_BITS-2:0] first_height,
    input  logic signed [COORD_BITS-1:0] second_left,
    input  logic signed [COORD_BITS-1:0] second_top,
    input  logic        [COORD_BITS-2:0] second_width,
    input  logic        [COORD_BITS-2:0] second_height,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [FRACTION_BITS:0]       overlap_ratio,
    output logic                         boxes_overlap
);

    localparam int AREA_BITS  = 2 * (COORD_BITS - 1);
    localparam int DEN_BITS   = AREA_BITS + 1;
    localparam int JOB_BITS   = AREA_BITS + DEN_BITS + 1;

    logic                 push_valid;
    logic [AREA_BITS-1:0] push_num;
    logic [DEN_BITS-1:0]  push_den;
    logic                 push_flag;
    logic [JOB_BITS-1:0]  push_data;
    logic                 job_valid;
    logic                 job_ready;
    logic [JOB_BITS-1:0]  job_data;
    queue_status_t        queue_status;

    // Geometry and area arithmetic.
    biou_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .first_left    (first_left),
        .first_top     (first_top),
        .first_width   (first_width),
        .first_height  (first_height),
        .second_left   (second_left),
        .second_top    (second_top),
        .second_width  (second_width),
        .second_height (second_height),
        .queue_status  (queue_status),
        .push_valid    (push_valid),
        .push_num      (push_num),
        .push_den      (push_den),
        .push_flag     (push_flag)
    );

    assign push_data = {push_num, push_den, push_flag};

    // Job queue between the front end and the divider.
    biou_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop_ready  (job_ready),
        .pop_valid  (job_valid),
        .pop_data   (job_data),
        .status     (queue_status)
    );

    // Fixed-point division of intersection by union.
    biou_divider #(
        .AREA_BITS     (AREA_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job_num       (job_data[JOB_BITS-1:DEN_BITS+1]),
        .job_den       (job_data[DEN_BITS:1]),
        .job_flag      (job_data[0]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .overlap_ratio (overlap_ratio),
        .boxes_overlap (boxes_overlap)
    );

endmodule
